### sv/fwir_pkg.sv
// Package: sizes, opcode and status codes, and cell control type for the indexed-remove FIFO.
package fwir_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int OPC_W  = 2;
  localparam int POS_W  = 4;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SEL_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OPC_W-1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_READ   = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

### sv/fwir_in_if.sv
// Interface: input channel carrying one operation word.
interface fwir_in_if import fwir_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [POS_W-1:0]  position;
  logic [WORD_W-1:0] data_in;

  modport source (output valid, opcode, position, data_in, input ready);
  modport sink   (input valid, opcode, position, data_in, output ready);
endinterface

### sv/fwir_out_if.sv
// Interface: result channel carrying one result word.
interface fwir_out_if import fwir_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_out;
  logic [STAT_W-1:0] status;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, data_out, status, occupancy, input ready);
  modport sink   (input valid, data_out, status, occupancy, output ready);
endinterface

### sv/fwir_cell.sv
// Storage cell: one queue slot that loads a new word or takes its right neighbor's word.
module fwir_cell import fwir_pkg::*; (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [DATA_WIDTH-1:0] right_d,
  input  logic [DATA_WIDTH-1:0] load_d,
  output logic [DATA_WIDTH-1:0] q
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = load_d;
    end else if (ctl.shift) begin
      data_nxt = right_d;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

### sv/fifo_with_indexed_remove.sv
// Top level: bounded FIFO with read and remove by position, built as a row of shifting cells.
//
// Usage:
//   in_ch carries one operation per word: enqueue, dequeue, read at position
//   or remove at position (position counted from the head, 0 = head).
//   out_ch returns exactly one result word per operation: the data word
//   (zero for enqueue and for refused operations), a status (ok, empty or
//   invalid position, full) and the occupancy after the operation.
//   The result is valid in the cycle after acceptance. Throughput is one
//   operation per cycle unless out_ch stalls: the whole queue sits in a row of
//   cells, and a dequeue or remove closes the gap in the same cycle by having
//   every cell at or after the removed slot take its right neighbor's word.
//   The read data comes from a position-selected mux over the cells.
//   Reset clears the entry count and the result valid flag; cell contents are
//   not cleared and are never returned before being written.
//   When out_ch stalls, the pending result holds in the output register and
//   in_ch.ready drops until the result is taken.
module fifo_with_indexed_remove import fwir_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  fwir_in_if.sink   in_ch,
  fwir_out_if.source out_ch
);

  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  cell_ctl_t             cell_ctl [DEPTH];

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [WORD_W-1:0] out_data_r;
  logic [STAT_W-1:0] out_status_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic                  in_fire;
  op_t                   op;
  logic [SEL_W-1:0]      pos_w;
  logic [SEL_W-1:0]      cnt_w;
  logic [SEL_W-1:0]      shift_from;
  logic                  pos_ok;
  logic                  do_shift;
  logic                  do_load;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] enq_data;
  logic [WORD_W-1:0]     res_data;
  status_t               res_status;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign op       = op_t'(in_ch.opcode);
  assign pos_w    = SEL_W'(in_ch.position);
  assign cnt_w    = SEL_W'(count_r);
  assign pos_ok   = pos_w < cnt_w;
  assign enq_data = DATA_WIDTH'(in_ch.data_in);

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_w == SEL_W'(i)) begin
        rd_data = cell_q[i];
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    res_data   = '0;
    res_status = ST_OK;
    do_shift   = 1'b0;
    do_load    = 1'b0;
    shift_from = pos_w;
    case (op)
      OP_ENQ: begin
        if (count_r == CNT_W'(DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          do_load   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        shift_from = '0;
        if (count_r == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_data  = WORD_W'(cell_q[0]);
          do_shift  = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_READ, OP_REMOVE: begin
        if (!pos_ok) begin
          res_status = ST_EMPTY;
        end else begin
          res_data = WORD_W'(rd_data);
          if (op == OP_REMOVE) begin
            do_shift  = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        res_status = ST_EMPTY;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign cell_ctl[g].shift = in_fire && do_shift && (SEL_W'(g) >= shift_from);
    assign cell_ctl[g].load  = in_fire && do_load && (CNT_W'(g) == count_r);

    fwir_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[g]),
      .right_d ((g == DEPTH - 1) ? cell_q[g] : cell_q[(g == DEPTH - 1) ? g : g + 1]),
      .load_d  (enq_data),
      .q       (cell_q[g])
    );
  end

  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = in_fire || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r   <= res_data;
      out_status_r <= res_status;
      out_occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.data_out  = out_data_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.occupancy = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (res_status != ST_OK) |=> count_r == $past(count_r))
    else $error("refused operation changed the count");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> out_data_r == '0)
    else $error("refused operation returned nonzero data");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (op == OP_ENQ) && (count_r == CNT_W'(DEPTH)) |=> out_status_r == ST_FULL)
    else $error("enqueue on full queue not flagged");

  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_fire) |-> out_occ_r == OCC_W'(count_r))
    else $error("reported occupancy differs from count");

endmodule
